/* sv/lfu_pkg.sv */
// lfu_pkg: shared types and constants of the LFU cache table.
// Used by lfu_cell, lfu_cache_table and the testbench; depends on nothing else.
package lfu_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int CNT_W   = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(DEPTH);
    localparam logic [CNT_W-1:0] COUNT_ONE      = CNT_W'(1);
    localparam logic [CNT_W-1:0] COUNT_MAX      = '1;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [KEY_W-1:0]   lookup_key;
        logic [VALUE_W-1:0] write_value;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] read_value;
        logic               evicted;
        logic [KEY_W-1:0]   evicted_key;
    } out_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_MOVE,
        CELL_INSERT
    } cell_op_t;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [CNT_W-1:0]   count;
    } entry_t;

    // Broadcast from the controller to every cell in the update cycle.
    typedef struct packed {
        cell_op_t         op;
        logic [CNT_W-1:0] thresh;
        entry_t           place;
    } cell_cmd_t;

    // What a cell shows its two neighbors.
    typedef struct packed {
        entry_t entry;
        logic   le;
        logic   seen;
    } cell_link_t;

endpackage

/* sv/lfu_cell.sv */
// lfu_cell: one position of the ordered entry chain (position 0 is the victim).
// Depends on lfu_pkg for the entry, link and command types.
module lfu_cell
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             capture,
    input  logic [lfu_pkg::KEY_W-1:0]        capture_key,
    input  lfu_pkg::cell_cmd_t               cmd,
    input  logic                             anchor_force,
    input  lfu_pkg::cell_link_t              prev_link,
    input  lfu_pkg::cell_link_t              next_link,
    output lfu_pkg::cell_link_t              link,
    output logic                             match
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [lfu_pkg::KEY_W-1:0]     key_reg;
    logic [lfu_pkg::KEY_W-1:0]     key_next;
    logic [lfu_pkg::VALUE_W-1:0]   value_reg;
    logic [lfu_pkg::VALUE_W-1:0]   value_next;
    logic [lfu_pkg::CNT_W-1:0]     count_reg;
    logic [lfu_pkg::CNT_W-1:0]     count_next;
    logic                          match_reg;
    logic                          match_next;

    logic le;
    logic anchor;
    logic seen;
    logic take_next;
    logic take_prev;
    logic place;

    // Entry with count at or below the threshold (moves ahead of the placed entry).
    assign le     = valid_reg && (count_reg <= cmd.thresh);
    assign anchor = anchor_force | match_reg;
    assign seen   = prev_link.seen | anchor;

    assign link.entry.valid = valid_reg;
    assign link.entry.key   = key_reg;
    assign link.entry.value = value_reg;
    assign link.entry.count = count_reg;
    assign link.le          = le;
    assign link.seen        = seen;
    assign match            = match_reg;

    assign match_next = capture ? (valid_reg && (key_reg == capture_key)) : match_reg;

    always_comb
    begin
        take_next  = 1'b0;
        take_prev  = 1'b0;
        place      = 1'b0;
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        count_next = count_reg;
        case (cmd.op)
            lfu_pkg::CELL_MOVE:
            begin
                // Close the gap left at the anchor, drop the placed entry at the boundary.
                take_next = seen && next_link.le;
                place     = seen && !next_link.le && (anchor || le);
            end
            lfu_pkg::CELL_INSERT:
            begin
                // Open a gap behind the low-count run.
                take_prev = prev_link.entry.valid && !prev_link.le;
                place     = prev_link.le && !le;
            end
            default:
            begin
            end
        endcase
        if (take_next)
        begin
            valid_next = next_link.entry.valid;
            key_next   = next_link.entry.key;
            value_next = next_link.entry.value;
            count_next = next_link.entry.count;
        end
        else if (take_prev)
        begin
            valid_next = prev_link.entry.valid;
            key_next   = prev_link.entry.key;
            value_next = prev_link.entry.value;
            count_next = prev_link.entry.count;
        end
        else if (place)
        begin
            valid_next = cmd.place.valid;
            key_next   = cmd.place.key;
            value_next = cmd.place.value;
            count_next = cmd.place.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
        count_reg <= count_next;
    end

endmodule

/* sv/lfu_cache_table.sv */
// lfu_cache_table: LFU cache with least-recently-placed tie break, top level.
// Depends on lfu_pkg and lfu_cell.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------
//   in       | sink      | in_valid / in_stall   | in_data  (mode, key, value)
//   out      | source    | out_valid / out_stall | out_data (found, read, evict)
//   cfg      | sink      | cfg_wr_en             | cfg_wr_data (capacity)
//
// For each transaction, the accept edge registers the operation and
// latches per-cell key matches; the next edge moves the chain of cells one step
// and loads the result register. That step holds the chain update (hit gather,
// count increment, per-cell compare and neighbor shift). Reset clears the
// cells' valid bits, the FSM and the result valid flag and loads capacity 16;
// no clearing pass. While a result waits under out_stall, hold the input side.
module lfu_cache_table
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  lfu_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output lfu_pkg::out_item_t             out_data,
    input  logic                           cfg_wr_en,
    input  logic [lfu_pkg::CAP_W-1:0]      cfg_wr_data
);

    lfu_pkg::state_t                state_reg;
    lfu_pkg::state_t                state_next;
    lfu_pkg::in_item_t              op_reg;
    lfu_pkg::in_item_t              op_next;
    logic [lfu_pkg::CAP_W-1:0]      cap_reg;
    logic [lfu_pkg::CAP_W-1:0]      cap_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    lfu_pkg::out_item_t             out_data_reg;
    lfu_pkg::out_item_t             out_data_next;

    logic                           in_accept;
    logic                           out_accept;
    logic [lfu_pkg::CAP_W-1:0]      cap_eff;
    logic                           enabled;
    logic                           full;
    logic                           hit_any;
    logic                           is_put;
    lfu_pkg::entry_t                hit_entry;
    logic [lfu_pkg::CNT_W-1:0]      new_count;
    lfu_pkg::cell_cmd_t             cmd;
    logic                           evict_now;

    lfu_pkg::cell_link_t            link_arr [lfu_pkg::DEPTH];
    logic [lfu_pkg::DEPTH-1:0]      match_vec;
    logic [lfu_pkg::DEPTH-1:0]      valid_vec;
    lfu_pkg::cell_link_t            head_link;
    lfu_pkg::cell_link_t            tail_link;

    // Handshake: take a new transaction only when idle and the result slot frees up.
    assign in_stall   = (state_reg != lfu_pkg::ST_IDLE) || (out_valid_reg && out_stall);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // Boundary links: nothing ahead of position 0, nothing behind the last position.
    always_comb
    begin
        head_link       = '0;
        head_link.le    = 1'b1;
        tail_link       = '0;
    end

    // Capacity above the table depth acts as the full depth.
    assign cap_eff = (cap_reg > lfu_pkg::CAP_W'(lfu_pkg::DEPTH)) ?
                     lfu_pkg::CAP_W'(lfu_pkg::DEPTH) : cap_reg;
    assign enabled = (cap_eff != '0);
    // Valid cells form a prefix, so the table is full when the last usable one is valid.
    assign full    = valid_vec[lfu_pkg::IDX_W'(cap_eff - lfu_pkg::CAP_W'(1))];
    assign is_put  = (op_reg.mode == lfu_pkg::MODE_PUT);
    assign hit_any = |match_vec;

    // Gather the matching cell (at most one) by an AND-OR over the row.
    always_comb
    begin
        hit_entry = '0;
        for (int i = 0; i < lfu_pkg::DEPTH; i++)
        begin
            if (match_vec[i])
            begin
                hit_entry = hit_entry | link_arr[i].entry;
            end
        end
    end

    assign new_count = (hit_entry.count == lfu_pkg::COUNT_MAX) ?
                       hit_entry.count : hit_entry.count + lfu_pkg::COUNT_ONE;

    // FSM, operation latch, capacity register and result register.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cap_next       = cap_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        cmd            = '0;
        cmd.op         = lfu_pkg::CELL_HOLD;
        evict_now      = 1'b0;

        if (cfg_wr_en)
        begin
            cap_next = cfg_wr_data;
        end
        if (out_accept)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next    = in_data;
                    state_next = lfu_pkg::ST_UPDATE;
                end
            end
            lfu_pkg::ST_UPDATE:
            begin
                out_data_next  = '0;
                out_valid_next = 1'b1;
                state_next     = lfu_pkg::ST_IDLE;
                if (enabled)
                begin
                    if (hit_any)
                    begin
                        // Hit: bump the count and move the entry behind its peers.
                        cmd.op          = lfu_pkg::CELL_MOVE;
                        cmd.thresh      = new_count;
                        cmd.place.valid = 1'b1;
                        cmd.place.key   = hit_entry.key;
                        cmd.place.value = is_put ? op_reg.write_value : hit_entry.value;
                        cmd.place.count = new_count;
                        out_data_next.found      = 1'b1;
                        out_data_next.read_value = is_put ? '0 : hit_entry.value;
                    end
                    else if (is_put)
                    begin
                        // New key: count one, placed behind all count-one entries.
                        cmd.thresh      = lfu_pkg::COUNT_ONE;
                        cmd.place.valid = 1'b1;
                        cmd.place.key   = op_reg.lookup_key;
                        cmd.place.value = op_reg.write_value;
                        cmd.place.count = lfu_pkg::COUNT_ONE;
                        if (full)
                        begin
                            // Drop position 0 and close up as if it were the hit.
                            cmd.op                    = lfu_pkg::CELL_MOVE;
                            evict_now                 = 1'b1;
                            out_data_next.evicted     = 1'b1;
                            out_data_next.evicted_key = link_arr[0].entry.key;
                        end
                        else
                        begin
                            cmd.op = lfu_pkg::CELL_INSERT;
                        end
                    end
                end
            end
            default:
            begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfu_pkg::ST_IDLE;
            cap_reg       <= lfu_pkg::CAPACITY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        out_data_reg <= out_data_next;
    end

    // Row of cells in eviction order; each talks only to its two neighbors.
    for (genvar i = 0; i < lfu_pkg::DEPTH; i++)
    begin : g_cell
        lfu_pkg::cell_link_t prev_l;
        lfu_pkg::cell_link_t next_l;
        logic                force_l;

        if (i == 0)
        begin : g_head
            assign prev_l  = head_link;
            assign force_l = evict_now;
        end
        else
        begin : g_body
            assign prev_l  = link_arr[i-1];
            assign force_l = 1'b0;
        end

        if (i == lfu_pkg::DEPTH - 1)
        begin : g_tail
            assign next_l = tail_link;
        end
        else
        begin : g_inner
            assign next_l = link_arr[i+1];
        end

        lfu_cell u_cell
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .capture      (in_accept),
            .capture_key  (in_data.lookup_key),
            .cmd          (cmd),
            .anchor_force (force_l),
            .prev_link    (prev_l),
            .next_link    (next_l),
            .link         (link_arr[i]),
            .match        (match_vec[i])
        );

        assign valid_vec[i] = link_arr[i].entry.valid;
    end

    // Keys are unique, so at most one cell matches.
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lfu_pkg::ST_UPDATE) |-> $onehot0(match_vec))
        else $error("more than one cell matched the key");

    // Valid cells always stay packed at the front of the row.
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + lfu_pkg::DEPTH'(1))) == '0)
        else $error("valid cells are not a prefix of the row");

    // Every accepted transaction raises the result valid flag after its update state.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> ##1 out_valid_reg)
        else $error("accepted transaction produced no result");

    // An update leaves the occupancy unchanged or raises it by one entry.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lfu_pkg::ST_UPDATE) |=>
        ($countones(valid_vec) == $countones($past(valid_vec))) ||
        ($countones(valid_vec) == $countones($past(valid_vec)) + 1))
        else $error("occupancy changed by more than one");

endmodule

/* tb/lfu_cache_table_test.sv */
`timescale 1ns / 100ps
// lfu_cache_table_test: self-checking testbench of the LFU cache table, with an
// ordered-list model of the cache, a directed table and randomized traffic.
// Depends on lfu_pkg and lfu_cache_table.
module lfu_cache_table_test;

    import lfu_pkg::*;

    localparam int HALF_PERIOD       = 5;
    localparam int RESET_CYCLES      = 3;
    localparam int SETTLE_CYCLES     = 4;    // settling time before a capacity write
    localparam int DRAIN_CYCLES      = 8;
    localparam int WATCHDOG_LIMIT    = 2000; // cycles with no transaction on the in or out channel
    localparam int ITEMS_PER_SETTING = 160;
    localparam int KEY_POOL_SIZE     = 24;

    // Row kinds and checking modes of the directed table.
    localparam logic ROW_OP      = 1'b0;
    localparam logic ROW_CFG     = 1'b1;
    localparam logic CHECK_MODEL = 1'b0;
    localparam logic CHECK_TYPED = 1'b1;

    localparam in_item_t  NO_OP    = '0;
    localparam out_item_t NO_REPLY = '0;

    // Idling per phase: receiver mostly stalling first, then sender mostly idle, then no idling.
    localparam int SEND_IDLE_PCT [3] = '{12, 52, 0};
    localparam int RECV_IDLE_PCT [3] = '{52, 12, 0};

    // Capacity settings of the random part, three per idling phase. Lowering
    // from 16 to 3 and from 31 to 1 leaves occupancy above the capacity.
    localparam logic [CAP_W-1:0] CAPACITY_PLAN [9] = '{
        5'd16, 5'd3, 5'd31,
        5'd1, 5'd17, 5'd8,
        5'd5, 5'd2, 5'd16
    };

    typedef struct packed {
        logic               is_cfg;
        logic [CAP_W-1:0]   capacity;
        logic               check;
        in_item_t           op;
        out_item_t          reply;
    } dir_row_t;

    // One held cache line; the list below keeps them in eviction order.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [CNT_W-1:0]   uses;
    } cache_line_t;

    // Directed rows. Typed replies follow from the rows above them at a glance;
    // the rest are taken from the cache model.
    dir_row_t directed_rows [23] = '{
        // empty table: miss on get, plain insert on put, hits afterwards
        '{ROW_OP, 5'd0, CHECK_TYPED, '{MODE_GET, 32'h0, 32'h0}, NO_REPLY},
        '{ROW_OP, 5'd0, CHECK_TYPED, '{MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, NO_REPLY},
        '{ROW_OP, 5'd0, CHECK_TYPED, '{MODE_GET, 32'hFFFF_FFFF, 32'h0},
            '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
        '{ROW_OP, 5'd0, CHECK_TYPED, '{MODE_PUT, 32'h0, 32'h0}, NO_REPLY},
        '{ROW_OP, 5'd0, CHECK_TYPED, '{MODE_GET, 32'h0, 32'hFFFF_FFFF},
            '{1'b1, 32'h0, 1'b0, 32'h0}},
        // update of a present key: found, no read data, no eviction
        '{ROW_OP, 5'd0, CHECK_TYPED, '{MODE_PUT, 32'hFFFF_FFFF, 32'h1234_5678},
            '{1'b1, 32'h0, 1'b0, 32'h0}},
        '{ROW_OP, 5'd0, CHECK_MODEL, '{MODE_GET, 32'hFFFF_FFFF, 32'h0}, NO_REPLY},
        // full table at capacity 2: key 0 has the lower count and goes
        '{ROW_CFG, 5'd2, CHECK_MODEL, NO_OP, NO_REPLY},
        '{ROW_OP, 5'd0, CHECK_TYPED, '{MODE_PUT, 32'h5, 32'hAAAA_5555},
            '{1'b0, 32'h0, 1'b1, 32'h0}},
        '{ROW_OP, 5'd0, CHECK_MODEL, '{MODE_GET, 32'h5, 32'h0}, NO_REPLY},
        // capacity zero: everything returns zeros and nothing changes
        '{ROW_CFG, 5'd0, CHECK_MODEL, NO_OP, NO_REPLY},
        '{ROW_OP, 5'd0, CHECK_TYPED, '{MODE_PUT, 32'h7, 32'h1}, NO_REPLY},
        '{ROW_OP, 5'd0, CHECK_TYPED, '{MODE_GET, 32'hFFFF_FFFF, 32'h0}, NO_REPLY},
        // capacity above the depth, then ties at count 1, then a miss
        '{ROW_CFG, 5'd31, CHECK_MODEL, NO_OP, NO_REPLY},
        '{ROW_OP, 5'd0, CHECK_MODEL, '{MODE_PUT, 32'hA, 32'h5555_AAAA}, NO_REPLY},
        '{ROW_OP, 5'd0, CHECK_MODEL, '{MODE_PUT, 32'hB, 32'h8000_0001}, NO_REPLY},
        '{ROW_OP, 5'd0, CHECK_MODEL, '{MODE_GET, 32'h7, 32'h0}, NO_REPLY},
        // capacity lowered below occupancy: each new key evicts exactly one
        '{ROW_CFG, 5'd1, CHECK_MODEL, NO_OP, NO_REPLY},
        '{ROW_OP, 5'd0, CHECK_MODEL, '{MODE_PUT, 32'hC, 32'h7FFF_FFFE}, NO_REPLY},
        '{ROW_OP, 5'd0, CHECK_MODEL, '{MODE_PUT, 32'hA, 32'h0}, NO_REPLY},
        '{ROW_OP, 5'd0, CHECK_MODEL, '{MODE_GET, 32'hC, 32'h0}, NO_REPLY},
        '{ROW_OP, 5'd0, CHECK_MODEL, '{MODE_GET, 32'hFFFF_FFFF, 32'h0}, NO_REPLY},
        '{ROW_CFG, 5'd16, CHECK_MODEL, NO_OP, NO_REPLY}
    };

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    in_item_t            in_data     = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    out_item_t           out_data;
    logic                cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]    cfg_wr_data = '0;

    // Model state: the held lines in eviction order and the capacity register.
    cache_line_t         cache_lines [$];
    logic [CAP_W-1:0]    capacity_model = CAPACITY_RESET;
    // Replies of accepted transactions, oldest first.
    out_item_t           cache_replies [$];
    logic [KEY_W-1:0]    key_pool [KEY_POOL_SIZE];

    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  mismatch_count = 0;
    int                  quiet_cycles = 0;

    lfu_cache_table u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Apply one cache access to the model and return the reply it gives.
    function automatic out_item_t cache_access(in_item_t op);
        out_item_t   res;
        cache_line_t line;
        int          hit;
        int          eff_cap;
        int          q;
        res = '0;
        hit = -1;
        eff_cap = (capacity_model > CAP_W'(DEPTH)) ? DEPTH : int'(capacity_model);
        if (eff_cap == 0)
            return res;
        foreach (cache_lines[i])
            if (hit < 0 && cache_lines[i].key == op.lookup_key)
                hit = i;
        if (hit >= 0)
        begin
            // Hit: bump the count (saturating) and move the line behind every
            // line whose count does not exceed the new one.
            line = cache_lines[hit];
            if (line.uses != COUNT_MAX)
                line.uses = line.uses + 1;
            if (op.mode == MODE_PUT)
                line.value = op.write_value;
            else
                res.read_value = line.value;
            res.found = 1'b1;
            cache_lines.delete(hit);
            q = hit;
            while (q < cache_lines.size() && cache_lines[q].uses <= line.uses)
                q++;
            cache_lines.insert(q, line);
            return res;
        end
        if (op.mode == MODE_GET)
            return res;
        // New key: drop the head of the order when full (occupancy left above
        // a lowered capacity still counts as full), then insert at count 1.
        if (cache_lines.size() >= eff_cap)
        begin
            res.evicted = 1'b1;
            res.evicted_key = cache_lines[0].key;
            cache_lines.delete(0);
        end
        line.key = op.lookup_key;
        line.value = op.write_value;
        line.uses = COUNT_ONE;
        q = 0;
        while (q < cache_lines.size() && cache_lines[q].uses <= COUNT_ONE)
            q++;
        cache_lines.insert(q, line);
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Drive one transaction, idling first at random, and hold it until the
    // block takes it. Record the reply at the accepting edge.
    task automatic send_op(in_item_t op, logic check, out_item_t typed_reply);
        out_item_t modeled;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= op;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        modeled = cache_access(op);
        cache_replies.push_back((check == CHECK_TYPED) ? typed_reply : modeled);
    endtask

    // Write capacity only with the block idle: drop valid, drain every
    // outstanding reply, let the last update settle, then write.
    task automatic apply_capacity(logic [CAP_W-1:0] value);
        in_valid <= 1'b0;
        while (cache_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en      <= 1'b1;
        cfg_wr_data    <= value;
        capacity_model = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly keys from a small pool so hits, updates and evictions dominate;
    // the rest are fully random keys and the two extreme keys.
    function automatic in_item_t random_op(int pool_n);
        in_item_t op;
        int       pick;
        pick = $urandom_range(0, 99);
        op.mode = 1'($urandom_range(0, 1));
        op.write_value = $urandom;
        if (pick < 85)
            op.lookup_key = key_pool[$urandom_range(0, pool_n - 1)];
        else if (pick < 95)
            op.lookup_key = $urandom;
        else
            op.lookup_key = (pick < 97) ? '0 : '1;
        return op;
    endfunction

    // Receiver: stall at random per cycle.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // Compare each accepted reply with the oldest recorded one, field by field.
    always @(posedge clk)
    begin : check_replies
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cache_replies.size() == 0)
                report_mismatch($sformatf("reply with no transaction pending: %h", out_data));
            else
            begin
                want = cache_replies.pop_front();
                if (out_data.found !== want.found)
                    report_mismatch($sformatf("found %b, want %b",
                                              out_data.found, want.found));
                if (out_data.read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %h, want %h",
                                              out_data.read_value, want.read_value));
                if (out_data.evicted !== want.evicted)
                    report_mismatch($sformatf("evicted %b, want %b",
                                              out_data.evicted, want.evicted));
                if (out_data.evicted_key !== want.evicted_key)
                    report_mismatch($sformatf("evicted_key %h, want %h",
                                              out_data.evicted_key, want.evicted_key));
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired at %0t", $realtime);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        in_item_t op;
        int       pool_n;
        int       eff_cap;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, starting at reset capacity, under the first idling mix.
        send_idle_pct = SEND_IDLE_PCT[0];
        recv_idle_pct = RECV_IDLE_PCT[0];
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].is_cfg == ROW_CFG)
                apply_capacity(directed_rows[r].capacity);
            else
                send_op(directed_rows[r].op, directed_rows[r].check,
                        directed_rows[r].reply);
        end

        // Random traffic: three idling mixes, three capacities each.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = SEND_IDLE_PCT[ph];
            recv_idle_pct = RECV_IDLE_PCT[ph];
            for (int s = 0; s < 3; s++)
            begin
                apply_capacity(CAPACITY_PLAN[ph * 3 + s]);
                eff_cap = (capacity_model > CAP_W'(DEPTH)) ? DEPTH : int'(capacity_model);
                // Size the pool a little above capacity so the table churns.
                pool_n = (eff_cap + 4 > KEY_POOL_SIZE) ? KEY_POOL_SIZE : eff_cap + 4;
                foreach (key_pool[i])
                    key_pool[i] = $urandom;
                key_pool[0] = '0;
                key_pool[1] = '1;
                for (int k = 0; k < ITEMS_PER_SETTING; k++)
                begin
                    op = random_op(pool_n);
                    send_op(op, CHECK_MODEL, NO_REPLY);
                end
            end
        end

        // Drain the remaining replies, then wait for stray output.
        in_valid <= 1'b0;
        while (cache_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
sv/lfu_pkg.sv
sv/lfu_cell.sv
sv/lfu_cache_table.sv
tb/lfu_cache_table_test.sv
